// ===== rtl/wall_centering_steering_mix_assert.svh =====
// assertion macros for the steering mixer
`ifndef WALL_CENTERING_STEERING_MIX_ASSERT_SVH
`define WALL_CENTERING_STEERING_MIX_ASSERT_SVH

`ifndef ASSERT_OFF
`define WCSM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wcsm assertion failed");
`define WCSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wcsm assertion failed");
`else
`define WCSM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WCSM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/wcsm_pkg.sv =====
package wcsm_pkg;

    localparam int DIST_W = 13;
    localparam int SUM_W  = 15;
    localparam int GAP_W  = 10;
    localparam int ANT_W  = 23;
    localparam int SC_W   = 37;
    localparam int NUM_W  = 42;
    localparam int LAT    = 8;

    localparam logic [12:0] REPLACE_DIST = 13'd2000;
    localparam logic [12:0] PROX_LIMIT   = 13'd1200;
    localparam logic [12:0] CURVE_LIMIT  = 13'd800;
    localparam logic [7:0]  PROX_STEPS   = 8'd150;
    localparam logic [6:0]  CORR_LIMIT   = 7'd120;
    localparam logic [7:0]  MIN_STEER    = 8'd30;
    localparam logic [7:0]  DIR_DEADBAND = 8'd15;

    // x / 3 == (x * 43691) >> 17 for x < 2^16
    localparam logic [15:0] DIV3_MUL   = 16'd43691;
    // t / 15 == (t * 4370) >> 16 for t < 1815
    localparam logic [12:0] DIV15_MUL  = 13'd4370;
    localparam logic [19:0] DIV15_SAT  = 20'd1815;

    localparam logic [12:0] THR_RESET  = 13'd8190;
    localparam logic [7:0]  BASE_RESET = 8'd150;
    localparam logic [11:0] CG_RESET   = 12'd256;
    localparam logic [11:0] AG_RESET   = 12'd256;

    typedef enum logic [1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_BASE      = 2'd1,
        CFG_CGAIN     = 2'd2,
        CFG_AGAIN     = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIR_STRAIGHT = 2'd0,
        DIR_RIGHT    = 2'd1,
        DIR_LEFT     = 2'd2
    } t_dir;

    typedef struct packed {
        logic                     valid;
        logic [DIST_W-1:0]        avg_l;
        logic [DIST_W-1:0]        avg_r;
        logic signed [ANT_W-1:0]  ant_net;
    } t_avg_beat;

    typedef struct packed {
        logic                     valid;
        logic signed [NUM_W-1:0]  num;
    } t_num_beat;

    typedef logic [12:0] t_prox_tab [0:150];

    // round(4096 * (k/150)^1.5), built at elaboration
    function automatic t_prox_tab prox_tab_build();
        t_prox_tab       tab;
        longint unsigned a4;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned t;
        for (int k = 0; k <= 150; k++) begin
            a4 = 64'd67108864 * longint'(k) * longint'(k) * longint'(k);
            lo = 0;
            hi = 4096;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                t   = 2 * mid - 1;
                if (t * t * 64'd3375000 <= a4) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
            tab[k] = lo[12:0];
        end
        return tab;
    endfunction

    localparam t_prox_tab PROX_TAB = prox_tab_build();

endpackage

// ===== rtl/wcsm_frontend.sv =====
module wcsm_frontend
    import wcsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [DIST_W-1:0] i_fl,
    input  logic [DIST_W-1:0] i_l,
    input  logic [DIST_W-1:0] i_bl,
    input  logic [DIST_W-1:0] i_br,
    input  logic [DIST_W-1:0] i_r,
    input  logic [DIST_W-1:0] i_fr,
    input  logic [DIST_W-1:0] i_thr,
    input  logic [11:0]       i_ag,
    output t_avg_beat         o_beat
);

    function automatic logic [DIST_W-1:0] clean_dist(input logic [DIST_W-1:0] d,
                                                     input logic [DIST_W-1:0] thr);
        return (d < thr) ? d : REPLACE_DIST;
    endfunction

    function automatic logic [GAP_W-1:0] curve_gap(input logic [DIST_W-1:0] d,
                                                   input logic [DIST_W-1:0] thr);
        logic [DIST_W-1:0] diff;
        diff = CURVE_LIMIT - d;
        return (d < thr && d < CURVE_LIMIT) ? diff[GAP_W-1:0] : '0;
    endfunction

    // stage a: clean, side sums, curve gaps
    logic             r_a_valid;
    logic [SUM_W-1:0] r_sum_l, n_sum_l;
    logic [SUM_W-1:0] r_sum_r, n_sum_r;
    logic [GAP_W-1:0] r_gap_fl, n_gap_fl;
    logic [GAP_W-1:0] r_gap_fr, n_gap_fr;

    always_comb begin
        n_sum_l  = SUM_W'(clean_dist(i_l, i_thr)) + SUM_W'(clean_dist(i_bl, i_thr))
                 + SUM_W'(clean_dist(i_fl, i_thr));
        n_sum_r  = SUM_W'(clean_dist(i_r, i_thr)) + SUM_W'(clean_dist(i_br, i_thr))
                 + SUM_W'(clean_dist(i_fr, i_thr));
        n_gap_fl = curve_gap(i_fl, i_thr);
        n_gap_fr = curve_gap(i_fr, i_thr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum_l  <= n_sum_l;
        r_sum_r  <= n_sum_r;
        r_gap_fl <= n_gap_fl;
        r_gap_fr <= n_gap_fr;
    end

    // stage b: divide by three, anticipation products
    logic [30:0] prod_l, prod_r;
    logic [21:0] ant_l, ant_r;
    t_avg_beat   r_b, n_b;

    always_comb begin
        prod_l      = 31'(r_sum_l) * 31'(DIV3_MUL);
        prod_r      = 31'(r_sum_r) * 31'(DIV3_MUL);
        ant_l       = 22'(r_gap_fl) * 22'(i_ag);
        ant_r       = 22'(r_gap_fr) * 22'(i_ag);
        n_b.valid   = r_a_valid;
        n_b.avg_l   = prod_l[29:17];
        n_b.avg_r   = prod_r[29:17];
        n_b.ant_net = $signed({1'b0, ant_l}) - $signed({1'b0, ant_r});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.valid <= 1'b0;
        end else begin
            r_b.valid <= n_b.valid;
        end
        r_b.avg_l   <= n_b.avg_l;
        r_b.avg_r   <= n_b.avg_r;
        r_b.ant_net <= n_b.ant_net;
    end

    assign o_beat = r_b;

endmodule

// ===== rtl/wcsm_mix.sv =====
module wcsm_mix
    import wcsm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_avg_beat i_beat,
    input  logic [11:0] i_cg,
    output t_num_beat o_beat
);

    // stage c: balance, proximity lookup, scaled anticipation
    logic                    r_c_valid;
    logic [12:0]             r_s, n_s;
    logic signed [13:0]      r_delta, n_delta;
    logic signed [SC_W-1:0]  r_c_ant, n_c_ant;
    logic [DIST_W-1:0]       closest;
    logic [10:0]             clamped;
    logic [7:0]              k;
    logic signed [SC_W-1:0]  ant_ext;

    always_comb begin
        n_delta = $signed({1'b0, i_beat.avg_r}) - $signed({1'b0, i_beat.avg_l});
        closest = (i_beat.avg_l < i_beat.avg_r) ? i_beat.avg_l : i_beat.avg_r;
        clamped = (closest > PROX_LIMIT) ? PROX_LIMIT[10:0] : closest[10:0];
        k       = PROX_STEPS - clamped[10:3];
        n_s     = PROX_TAB[k];
        // times 7 * 1536
        ant_ext = SC_W'(i_beat.ant_net);
        n_c_ant = (ant_ext <<< 13) + (ant_ext <<< 11) + (ant_ext <<< 9);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= i_beat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s     <= n_s;
        r_delta <= n_delta;
        r_c_ant <= n_c_ant;
    end

    // stage d: strength times balance
    logic                    r_d_valid;
    logic signed [27:0]      r_m1, n_m1;
    logic signed [SC_W-1:0]  r_d_ant;

    assign n_m1 = $signed({1'b0, r_s}) * r_delta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1    <= n_m1;
        r_d_ant <= r_c_ant;
    end

    // stage e: gain, times five, add anticipation
    logic signed [40:0]      m2;
    logic signed [NUM_W-1:0] m2_ext;
    t_num_beat               r_e, n_e;

    always_comb begin
        m2        = 41'(r_m1) * 41'($signed({1'b0, i_cg}));
        m2_ext    = NUM_W'(m2);
        n_e.valid = r_d_valid;
        n_e.num   = (m2_ext <<< 2) + m2_ext + NUM_W'(r_d_ant);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.valid <= 1'b0;
        end else begin
            r_e.valid <= n_e.valid;
        end
        r_e.num <= n_e.num;
    end

    assign o_beat = r_e;

endmodule

// ===== rtl/wcsm_out.sv =====
module wcsm_out
    import wcsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_num_beat         i_beat,
    input  logic [7:0]        i_base,
    output logic              o_strobe,
    output logic [7:0]        o_left_speed,
    output logic [7:0]        o_right_speed,
    output logic signed [7:0] o_steer_correction,
    output logic [1:0]        o_steer_direction
);

    // stage f: magnitude over 2^21
    logic             r_f_valid;
    logic             r_neg, n_neg;
    logic             r_sat, n_sat;
    logic [10:0]      r_t, n_t;
    logic [NUM_W-1:0] mag;
    logic [19:0]      t_full;

    always_comb begin
        n_neg  = i_beat.num[NUM_W-1];
        mag    = n_neg ? NUM_W'(-i_beat.num) : NUM_W'(i_beat.num);
        t_full = mag[40:21];
        n_sat  = (t_full >= DIV15_SAT);
        n_t    = t_full[10:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else begin
            r_f_valid <= i_beat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
        r_sat <= n_sat;
        r_t   <= n_t;
    end

    // stage g: divide by 15, clamp, sign
    logic              r_g_valid;
    logic signed [7:0] r_c, n_c;
    logic [23:0]       q_prod;
    logic [6:0]        q;

    always_comb begin
        q_prod = 24'(r_t) * 24'(DIV15_MUL);
        q      = r_sat ? CORR_LIMIT : q_prod[22:16];
        n_c    = r_neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else begin
            r_g_valid <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c <= n_c;
    end

    // stage h: speeds and direction
    function automatic logic [7:0] clamp_speed(input logic signed [9:0] x,
                                               input logic signed [9:0] base);
        logic [9:0] xu;
        xu = x;
        if (x < $signed({2'b00, MIN_STEER})) begin
            return MIN_STEER;
        end else if (x > base) begin
            return base[7:0];
        end else begin
            return xu[7:0];
        end
    endfunction

    logic              r_h_valid;
    logic [7:0]        r_ls, n_ls;
    logic [7:0]        r_rs, n_rs;
    logic signed [7:0] r_corr;
    t_dir              r_dir, n_dir;
    logic signed [9:0] base_s;
    logic signed [9:0] c_s;

    always_comb begin
        base_s = $signed({2'b00, i_base});
        c_s    = 10'(r_c);
        if (r_c > 8'sd0) begin
            n_ls = clamp_speed(base_s - c_s, base_s);
            n_rs = clamp_speed(base_s, base_s);
        end else begin
            n_ls = clamp_speed(base_s, base_s);
            n_rs = clamp_speed(base_s + c_s, base_s);
        end
        if (r_c > $signed({1'b0, DIR_DEADBAND[6:0]})) begin
            n_dir = DIR_RIGHT;
        end else if (r_c < -$signed({1'b0, DIR_DEADBAND[6:0]})) begin
            n_dir = DIR_LEFT;
        end else begin
            n_dir = DIR_STRAIGHT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
        end else begin
            r_h_valid <= r_g_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ls   <= n_ls;
        r_rs   <= n_rs;
        r_corr <= r_c;
        r_dir  <= n_dir;
    end

    assign o_strobe           = r_h_valid;
    assign o_left_speed       = r_ls;
    assign o_right_speed      = r_rs;
    assign o_steer_correction = r_corr;
    assign o_steer_direction  = r_dir;

endmodule

// ===== rtl/wall_centering_steering_mix.sv =====
// Steering mixer for wall centering: takes one frame of seven distance
// readings per clock and returns both side speeds, the clamped correction
// and the steering direction through an eight-stage pipeline, on a
// one-cycle strobe. The port busy is low whenever reset is released, so a
// frame may enter every cycle, and results cannot be held off by the
// receiver. The user must write the four settings through the configuration
// channel only while no frame is in flight; the block itself does not enforce it.
`include "wall_centering_steering_mix_assert.svh"

module wall_centering_steering_mix
    import wcsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [12:0]       i_front_distance,
    input  logic [12:0]       i_front_left_distance,
    input  logic [12:0]       i_left_distance,
    input  logic [12:0]       i_back_left_distance,
    input  logic [12:0]       i_back_right_distance,
    input  logic [12:0]       i_right_distance,
    input  logic [12:0]       i_front_right_distance,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [12:0]       i_cfg_data,
    output logic              o_strobe,
    output logic [7:0]        o_left_speed,
    output logic [7:0]        o_right_speed,
    output logic signed [7:0] o_steer_correction,
    output logic [1:0]        o_steer_direction
);

    logic [12:0] r_thr;
    logic [7:0]  r_base;
    logic [11:0] r_cg;
    logic [11:0] r_ag;
    logic        cfg_we;
    logic        in_take;
    logic        front_seen;

    assign busy        = ~i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;
    assign in_take     = start & ~busy;
    // front reading rides along with the frame only
    assign front_seen  = |i_front_distance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= THR_RESET;
            r_base <= BASE_RESET;
            r_cg   <= CG_RESET;
            r_ag   <= AG_RESET;
        end else if (cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_THRESHOLD: r_thr  <= i_cfg_data;
                CFG_BASE:      r_base <= i_cfg_data[7:0];
                CFG_CGAIN:     r_cg   <= i_cfg_data[11:0];
                CFG_AGAIN:     r_ag   <= i_cfg_data[11:0];
            endcase
        end
    end

    t_avg_beat avg_beat;
    t_num_beat num_beat;

    wcsm_frontend u_frontend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_take | (in_take & front_seen)),
        .i_fl    (i_front_left_distance),
        .i_l     (i_left_distance),
        .i_bl    (i_back_left_distance),
        .i_br    (i_back_right_distance),
        .i_r     (i_right_distance),
        .i_fr    (i_front_right_distance),
        .i_thr   (r_thr),
        .i_ag    (r_ag),
        .o_beat  (avg_beat)
    );

    wcsm_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (avg_beat),
        .i_cg    (r_cg),
        .o_beat  (num_beat)
    );

    wcsm_out u_out (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_beat             (num_beat),
        .i_base             (r_base),
        .o_strobe           (o_strobe),
        .o_left_speed       (o_left_speed),
        .o_right_speed      (o_right_speed),
        .o_steer_correction (o_steer_correction),
        .o_steer_direction  (o_steer_direction)
    );

    // every result beat comes from a taken frame that has passed through all pipeline stages
    `WCSM_ASSERT_IMP(a_latency, i_clk, i_rst_n, o_strobe, $past(in_take, LAT))
    `WCSM_ASSERT_IMP(a_corr_range, i_clk, i_rst_n, o_strobe,
        (o_steer_correction <= 8'sd120) && (o_steer_correction >= -8'sd120))
    // steering right leaves the right side at its cruise speed, raised to MIN_STEER if below it
    `WCSM_ASSERT_IMP(a_right_cruise, i_clk, i_rst_n,
        o_strobe && (o_steer_correction > 8'sd0),
        (o_right_speed == r_base && r_base >= MIN_STEER)
        || (o_right_speed == MIN_STEER && r_base < MIN_STEER))
    `WCSM_ASSERT_NEXT(a_cfg_base, i_clk, i_rst_n, cfg_we && (i_cfg_index == CFG_BASE),
        r_base == $past(i_cfg_data[7:0]))

endmodule
